// ----- hw/rtl/nearest_palette_colour_macros.svh -----
// assertion macros for the nearest palette colour block
`ifndef NEAREST_PALETTE_COLOUR_MACROS_SVH
`define NEAREST_PALETTE_COLOUR_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define NPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");
// same-cycle implication
`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");
// next-cycle implication
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");
`else
`define NPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define NPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define NPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/npc_pkg.sv -----
// shared types and constants of the nearest palette colour block
`timescale 1ns / 1ps

package npc_pkg;

    // default palette capacity
    localparam int PALETTE_DEPTH_DEF = 256;

    // field widths
    localparam int CHAN_W   = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int NORM_W   = 3;

    // exponent after reset
    localparam logic [NORM_W-1:0] NORM_RESET = 3'd2;

    // request function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_FOUND = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    // exponent code after clamping, p minus one
    typedef enum logic [1:0] {
        POW_1 = 2'd0,
        POW_2 = 2'd1,
        POW_3 = 2'd2,
        POW_4 = 2'd3
    } t_pow;

    // clamp the raw exponent into 1..4
    function automatic t_pow clamp_pow(input logic [NORM_W-1:0] norm);
        t_pow res;
        case (norm)
            3'd0, 3'd1: res = POW_1;
            3'd2:       res = POW_2;
            3'd3:       res = POW_3;
            default:    res = POW_4;
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/npc_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module npc_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nearest_palette_colour.sv -----
// top level of the nearest palette colour block: sequencer and distance pipeline
`timescale 1ns / 1ps
`include "nearest_palette_colour_macros.svh"

// Nearest palette colour matcher.
// Input channel (i_in_valid / o_in_ready) carries one request: i_func selects
// append (add) or query, i_chan_b/g/r give the colour. Output channel
// (o_out_valid / i_out_ready) returns exactly one result per request:
// status, matched colour and palette index.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes norm_power,
// the distance exponent; write it only while no request is in flight.
// An add or an empty-palette query goes from acceptance to the done state and
// raises o_out_valid once its result is loaded. A query over N stored entries
// first issues one palette entry per cycle to the single ram read port, then
// diff, square, power, sum and compare stages drain into the output register.
// One request is in work at a time; o_in_ready is low from acceptance until
// the result has been loaded into the output register.
// Reset empties the palette (entry count zero, no clearing pass over the ram)
// and sets norm_power to 2. A stalled receiver holds the result in the output
// register; the next request may be accepted meanwhile but its result waits.
module nearest_palette_colour #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [npc_pkg::CHAN_W-1:0]    i_chan_b,
    input  logic [npc_pkg::CHAN_W-1:0]    i_chan_g,
    input  logic [npc_pkg::CHAN_W-1:0]    i_chan_r,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [npc_pkg::STATUS_W-1:0]  o_status,
    output logic [npc_pkg::CHAN_W-1:0]    o_out_b,
    output logic [npc_pkg::CHAN_W-1:0]    o_out_g,
    output logic [npc_pkg::CHAN_W-1:0]    o_out_r,
    output logic [npc_pkg::INDEX_W-1:0]   o_match_index,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [npc_pkg::NORM_W-1:0]    i_cfg_data
);

    import npc_pkg::*;

    localparam int AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW     = $clog2(PALETTE_DEPTH + 1);
    localparam int COL_W  = 3 * CHAN_W;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int PW_W   = 4 * CHAN_W;
    localparam int DIST_W = PW_W + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [NORM_W-1:0]   r_norm;
    t_pow                r_pow;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_issue;
    logic [CHAN_W-1:0]   r_q [3];

    // pending result
    t_status             r_res_status;
    logic [COL_W-1:0]    r_res_col;
    logic [AW-1:0]       r_res_idx;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [COL_W-1:0]    r_out_col;
    logic [INDEX_W-1:0]  r_out_idx;

    // distance pipeline
    logic                r_v0, r_v1, r_v2, r_v3, r_v4;
    logic                r_l0, r_l1, r_l2, r_l3, r_l4;
    logic [AW-1:0]       r_i0, r_i1, r_i2, r_i3, r_i4;
    logic [COL_W-1:0]    r_c1, r_c2, r_c3, r_c4;
    logic [CHAN_W-1:0]   r_d1 [3];
    logic [CHAN_W-1:0]   r_d2 [3];
    logic [SQ_W-1:0]     r_sq2 [3];
    logic [PW_W-1:0]     r_pw3 [3];
    logic [DIST_W-1:0]   r_sum4;

    // running best
    logic                r_have;
    logic [DIST_W-1:0]   r_best_dist;
    logic [AW-1:0]       r_best_idx;
    logic [COL_W-1:0]    r_best_col;

    logic                s_in_acc;
    logic                s_add_ok;
    logic                s_issue;
    logic                s_out_free;
    logic                s_load;
    logic                s_take;
    logic [COL_W-1:0]    s_rd_data;
    logic [CHAN_W-1:0]   s_rd_chan [3];
    logic [PW_W-1:0]     s_pw [3];
    logic [AW+7:0]       s_idx_wide;

    // handshakes
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign s_add_ok    = s_in_acc && (i_func == FUNC_ADD) && (r_count < DEPTH_C);
    assign s_issue     = (r_state == ST_SCAN) && (r_issue < r_count);
    assign s_out_free  = !r_out_valid || i_out_ready;
    assign s_load      = (r_state == ST_DONE) && s_out_free;

    // palette storage
    npc_ram #(
        .WIDTH (COL_W),
        .DEPTH (PALETTE_DEPTH),
        .ADDR_W(AW)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (s_add_ok),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_chan_b, i_chan_g, i_chan_r}),
        .i_raddr(r_issue[AW-1:0]),
        .o_rdata(s_rd_data)
    );

    assign s_rd_chan[0] = s_rd_data[3*CHAN_W-1:2*CHAN_W];
    assign s_rd_chan[1] = s_rd_data[2*CHAN_W-1:CHAN_W];
    assign s_rd_chan[2] = s_rd_data[CHAN_W-1:0];

    // power lane: cube and fourth power multiply the square by the difference or by itself
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_pow)
                POW_1:   s_pw[k] = PW_W'(r_d2[k]);
                POW_2:   s_pw[k] = PW_W'(r_sq2[k]);
                POW_3:   s_pw[k] = PW_W'(r_sq2[k]) * PW_W'(r_d2[k]);
                default: s_pw[k] = PW_W'(r_sq2[k]) * PW_W'(r_sq2[k]);
            endcase
        end
    end

    // compare stage: strict less keeps the lowest index on ties
    assign s_take = r_v4 && (!r_have || (r_sum4 < r_best_dist));

    // distance datapath
    always_ff @(posedge i_clk) begin
        r_i0 <= r_issue[AW-1:0];
        r_l0 <= (r_issue == (r_count - 1'b1));
        r_i1 <= r_i0;
        r_l1 <= r_l0;
        r_c1 <= s_rd_data;
        for (int k = 0; k < 3; k++) begin
            r_d1[k] <= (s_rd_chan[k] > r_q[k]) ? (s_rd_chan[k] - r_q[k])
                                               : (r_q[k] - s_rd_chan[k]);
            r_d2[k]  <= r_d1[k];
            r_sq2[k] <= SQ_W'(r_d1[k]) * SQ_W'(r_d1[k]);
            r_pw3[k] <= s_pw[k];
        end
        r_i2 <= r_i1;
        r_l2 <= r_l1;
        r_c2 <= r_c1;
        r_i3 <= r_i2;
        r_l3 <= r_l2;
        r_c3 <= r_c2;
        r_sum4 <= DIST_W'(r_pw3[0]) + DIST_W'(r_pw3[1]) + DIST_W'(r_pw3[2]);
        r_i4 <= r_i3;
        r_l4 <= r_l3;
        r_c4 <= r_c3;
        if (s_take) begin
            r_best_dist <= r_sum4;
            r_best_idx  <= r_i4;
            r_best_col  <= r_c4;
        end
    end

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_norm       <= NORM_RESET;
            r_pow        <= POW_2;
            r_count      <= '0;
            r_issue      <= '0;
            r_have       <= 1'b0;
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_status <= STAT_ADDED;
            r_out_status <= STAT_ADDED;
        end else begin
            if (i_cfg_valid) begin
                r_norm <= i_cfg_data;
            end
            r_v0 <= s_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (s_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_in_acc) begin
                        r_q[0]    <= i_chan_b;
                        r_q[1]    <= i_chan_g;
                        r_q[2]    <= i_chan_r;
                        r_res_idx <= '0;
                        r_issue   <= '0;
                        r_have    <= 1'b0;
                        r_pow     <= clamp_pow(r_norm);
                        if (i_func == FUNC_ADD) begin
                            r_state   <= ST_DONE;
                            r_res_col <= '0;
                            if (s_add_ok) begin
                                r_count      <= r_count + 1'b1;
                                r_res_status <= STAT_ADDED;
                            end else begin
                                r_res_status <= STAT_FULL;
                            end
                        end else if (r_count == '0) begin
                            r_state      <= ST_DONE;
                            r_res_status <= STAT_EMPTY;
                            r_res_col    <= {i_chan_b, i_chan_g, i_chan_r};
                        end else begin
                            r_state   <= ST_SCAN;
                            r_res_col <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (s_issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (s_take) begin
                        r_have <= 1'b1;
                    end
                    if (r_v4 && r_l4) begin
                        r_state      <= ST_DONE;
                        r_res_status <= STAT_FOUND;
                        r_res_col    <= s_take ? r_c4 : r_best_col;
                        r_res_idx    <= s_take ? r_i4 : r_best_idx;
                    end
                end
                ST_DONE: begin
                    if (s_load) begin
                        r_out_status <= r_res_status;
                        r_out_col    <= r_res_col;
                        r_out_idx    <= s_idx_wide[7:0];
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_idx_wide = {8'd0, r_res_idx};

    // result ports
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_b       = r_out_col[3*CHAN_W-1:2*CHAN_W];
    assign o_out_g       = r_out_col[2*CHAN_W-1:CHAN_W];
    assign o_out_r       = r_out_col[CHAN_W-1:0];
    assign o_match_index = r_out_idx;

    // checks
    `NPC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C)
    `NPC_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, s_add_ok, r_count == $past(r_count) + 1'b1)
    `NPC_ASSERT_IMPLY(a_pipe_in_scan, i_clk, i_rst_n, r_v4, r_state == ST_SCAN)
    `NPC_ASSERT_IMPLY(a_found_in_range, i_clk, i_rst_n, (r_state == ST_DONE) && (r_res_status == STAT_FOUND), CW'(r_res_idx) < r_count)

endmodule
